/* sv/monotonic_timestamp_clock_core_assert.svh */
// assertion macros shared by the checker
`ifndef MONOTONIC_TIMESTAMP_CLOCK_CORE_ASSERT_SVH
`define MONOTONIC_TIMESTAMP_CLOCK_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define MTC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mtc assertion failed");

// next-cycle implication, held off during reset
`define MTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mtc assertion failed");

`endif

/* sv/mtc_pkg.sv */
// shared types, constants and stamp arithmetic for the timestamp clock
package mtc_pkg;

    localparam int SEC_BITS  = 40;
    localparam int NSEC_BITS = 30;

    localparam logic [NSEC_BITS:0]  NS_PER_SEC   = (NSEC_BITS + 1)'(1000000000);
    localparam logic [SEC_BITS-1:0] FUTURE_RESET = SEC_BITS'(30 * 24 * 3600);

    typedef enum logic [1:0] {
        CMD_GET           = 2'd0,
        CMD_SET_STRICT    = 2'd1,
        CMD_SET_NONSTRICT = 2'd2,
        CMD_SET_GET       = 2'd3
    } t_cmd;

    typedef logic [SEC_BITS-1:0]  t_sec;
    typedef logic [NSEC_BITS-1:0] t_nsec;

    typedef struct packed {
        t_sec  sec;
        t_nsec nsec;
    } t_stamp;

    typedef struct packed {
        t_cmd   cmd;
        t_stamp real_ts;
        t_stamp adv;
    } t_item;

    typedef struct packed {
        t_stamp real_ts;
        t_stamp stamp;
        logic   clamped;
    } t_result;

    // a strictly later than b, seconds first
    function automatic logic f_later(t_stamp a, t_stamp b);
        return (a.sec != b.sec) ? (a.sec > b.sec) : (a.nsec > b.nsec);
    endfunction

    // one nanosecond on, carrying into seconds
    function automatic t_stamp f_tick(t_stamp a);
        logic [NSEC_BITS:0] n;
        t_stamp             r;
        n     = {1'b0, a.nsec} + (NSEC_BITS + 1)'(1);
        r.sec = a.sec;
        if (n >= NS_PER_SEC) begin
            n     = n - NS_PER_SEC;
            r.sec = a.sec + SEC_BITS'(1);
        end
        r.nsec = n[NSEC_BITS-1:0];
        return r;
    endfunction

endpackage

/* sv/mtc_in_reg.sv */
// input register with stall towards the sender
module mtc_in_reg
    import mtc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_stall = r_valid & ~i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* sv/mtc_clock.sv */
// logical stamp and future limit state with the per-item update
module mtc_clock
    import mtc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    t_stamp r_stamp;
    t_sec   r_limit;
    t_stamp n_stamp;
    t_sec   n_limit;

    logic              is_set;
    logic              is_get;
    logic [SEC_BITS:0] lim;
    logic              far;
    t_stamp            t2;
    t_stamp            cand;
    t_stamp            base;
    t_stamp            view;

    always_comb begin
        is_set = (i_item.cmd != CMD_GET);
        is_get = (i_item.cmd == CMD_GET) || (i_item.cmd == CMD_SET_GET);
        lim    = {1'b0, i_item.real_ts.sec} + {1'b0, r_limit};
        far    = is_set && ({1'b0, i_item.adv.sec} >= lim);
        t2     = f_tick(f_tick(r_stamp));
        cand   = far ? t2 : i_item.adv;
        base   = far ? t2 : r_stamp;

        n_limit = r_limit;
        // excess over the limit point grows the limit to stamp minus real
        if (far && ({1'b0, t2.sec} > lim)) begin
            n_limit = t2.sec - i_item.real_ts.sec;
        end

        n_stamp = r_stamp;
        if (is_set) begin
            if (f_later(cand, base)) begin
                n_stamp = cand;
            end else if (i_item.cmd != CMD_SET_NONSTRICT) begin
                n_stamp = f_tick(base);
            end else begin
                n_stamp = base;
            end
        end

        view = n_stamp;
        if (is_get && !f_later(n_stamp, i_item.real_ts)) begin
            view = i_item.real_ts;
        end

        o_result.real_ts = i_item.real_ts;
        o_result.stamp   = view;
        o_result.clamped = far;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
            r_limit <= FUTURE_RESET;
        end else if (i_fire) begin
            r_stamp <= n_stamp;
            r_limit <= n_limit;
        end
    end

endmodule

/* sv/mtc_out_reg.sv */
// result register towards the receiver
module mtc_out_reg
    import mtc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_take,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_take   = i_valid & (~r_valid | ~i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= i_result;
        end
    end

endmodule

/* sv/monotonic_timestamp_clock_core.sv */
// an accepted item is held in the input register, its result in the result register
// throughput: one item per cycle while i_stall is low; stamp and limit update in a loop
// a stalled result holds while the input register still takes one more item
// reset (synchronous, active low) empties both registers, clears the stamp
// and sets the future limit to thirty days
module monotonic_timestamp_clock_core
    import mtc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_cmd,
    input  logic [SEC_BITS-1:0]  i_real_sec,
    input  logic [NSEC_BITS-1:0] i_real_nsec,
    input  logic [SEC_BITS-1:0]  i_adv_sec,
    input  logic [NSEC_BITS-1:0] i_adv_nsec,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [SEC_BITS-1:0]  o_real_sec_out,
    output logic [NSEC_BITS-1:0] o_real_nsec_out,
    output logic [SEC_BITS-1:0]  o_stamp_sec,
    output logic [NSEC_BITS-1:0] o_stamp_nsec,
    output logic                 o_clamped
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    take;
    t_result next_result;
    t_result out_result;

    always_comb begin
        in_item.cmd          = t_cmd'(i_cmd);
        in_item.real_ts.sec  = i_real_sec;
        in_item.real_ts.nsec = i_real_nsec;
        in_item.adv.sec      = i_adv_sec;
        in_item.adv.nsec     = i_adv_nsec;
    end

    mtc_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .i_take  (take),
        .o_stall (o_stall),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    mtc_clock u_clock (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (take),
        .i_item   (held_item),
        .o_result (next_result)
    );

    mtc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .i_result (next_result),
        .i_stall  (i_stall),
        .o_take   (take),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_real_sec_out  = out_result.real_ts.sec;
    assign o_real_nsec_out = out_result.real_ts.nsec;
    assign o_stamp_sec     = out_result.stamp.sec;
    assign o_stamp_nsec    = out_result.stamp.nsec;
    assign o_clamped       = out_result.clamped;

endmodule

/* sv/mtc_checker.sv */
// port-level checker for the timestamp clock, bound to the top level
`include "monotonic_timestamp_clock_core_assert.svh"

module mtc_checker
    import mtc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic [1:0]           i_cmd,
    input logic [SEC_BITS-1:0]  i_real_sec,
    input logic [NSEC_BITS-1:0] i_real_nsec,
    input logic [SEC_BITS-1:0]  i_adv_sec,
    input logic [NSEC_BITS-1:0] i_adv_nsec,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [SEC_BITS-1:0]  o_real_sec_out,
    input logic [NSEC_BITS-1:0] o_real_nsec_out,
    input logic [SEC_BITS-1:0]  o_stamp_sec,
    input logic [NSEC_BITS-1:0] o_stamp_nsec,
    input logic                 o_clamped
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_cnt;
    logic [SEC_BITS+NSEC_BITS+SEC_BITS+NSEC_BITS:0] out_bus;

    assign in_acc  = i_valid & ~o_stall;
    assign out_acc = o_valid & ~i_stall;
    assign out_bus = {o_real_sec_out, o_real_nsec_out, o_stamp_sec, o_stamp_nsec, o_clamped};

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (!in_acc && out_acc) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    `MTC_ASSERT_IMPL(a_empty_after_reset, $past(!i_rst_n), !o_valid)
    `MTC_ASSERT_NEXT(a_result_holds, o_valid && i_stall, o_valid && $stable(out_bus))
    `MTC_ASSERT_IMPL(a_stall_only_when_full, o_stall, o_valid && i_stall)
    `MTC_ASSERT_IMPL(a_depth_two, r_cnt == 2'd2, !in_acc || out_acc)
    `MTC_ASSERT_IMPL(a_no_phantom, r_cnt == 2'd0, !o_valid)

endmodule

bind monotonic_timestamp_clock_core mtc_checker u_mtc_checker (.*);
